// ===== src/skrt_pkg.sv =====
// Shared types and constants for the sorted keyed record table.
// No dependencies.
package skrt_pkg;
	localparam int TABLE_DEPTH = 64;
	localparam int NAME_BYTES = 25;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int REC_W = 32 + 32 + 200;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_SEARCH = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_ERASE = 3'd3;
	localparam logic [2:0] OP_LIST = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	function automatic logic [199:0] name_mask();
		logic [199:0] m;
		m = '0;
		for (int i = 0; i < 25; i++) begin
			if (i < NAME_BYTES) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction
endpackage

// ===== src/sorted_keyed_record_table.sv =====
// Sorted keyed record table: one record memory plus a sequencer.
// Depends on skrt_pkg.
//
// Usage: requests enter on the input channel (valid/ready) with an operation
// code, a key, a quantity and a name. Results leave on the output channel
// (valid/ready), one per request except list, which gives one per record in
// ascending key order with last_result on the final one, or a single empty
// result on an empty table. Codes five to seven are dropped with no result.
// The records live in one synchronous memory with a registered read port.
// Insert, search, update and erase first scan from slot zero for the first
// key not below the request key; each slot is read, then compared. Insert
// then shifts the tail up one slot and erase shifts it down; each moved
// record is read, then written.
// One request is in work at a time; ready is low while a request is in work
// and while its last result waits for transfer.
// Reset empties the table at once; no clearing pass is needed.
// A stalled receiver holds the result register and the sequencer waits.
module sorted_keyed_record_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  operation,
	input  logic signed [31:0] part_key,
	input  logic signed [31:0] quantity_value,
	input  logic [63:0] name_word_a,
	input  logic [63:0] name_word_b,
	input  logic [63:0] name_word_c,
	input  logic [7:0]  name_word_d,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [31:0] out_key,
	output logic signed [31:0] out_quantity,
	output logic [63:0] out_name_a,
	output logic [63:0] out_name_b,
	output logic [63:0] out_name_c,
	output logic [7:0]  out_name_d,
	output logic        last_result
);
	localparam int IW = skrt_pkg::IDX_W;
	localparam int CW = skrt_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SCMP, S_DECIDE, S_UPD, S_INSRD, S_INSWR, S_INSFIN,
		S_ERRD, S_ERWR, S_ERFIN, S_LRD, S_LOUT, S_OUT
	} state_t;

	logic [skrt_pkg::REC_W-1:0] mem [skrt_pkg::TABLE_DEPTH];
	logic [skrt_pkg::REC_W-1:0] rd_q, wr_data;
	logic [IW-1:0] rd_addr, wr_addr;
	logic wr_en;

	state_t state_q;
	logic [CW-1:0] count_q, pos_q, idx_q;
	logic [2:0] op_q;
	logic signed [31:0] key_q, qty_q;
	logic [199:0] name_q;
	logic hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	logic signed [31:0] rd_key, rd_qty;
	logic signed [32:0] sum;
	logic signed [31:0] sat;
	assign rd_key = rd_q[263:232];
	assign rd_qty = rd_q[231:200];
	assign sum = 33'(rd_qty) + 33'(qty_q);
	always_comb begin
		if (sum > 33'sd2147483647) begin
			sat = 32'sh7fffffff;
		end else if (sum < -33'sd2147483648) begin
			sat = 32'sh80000000;
		end else begin
			sat = sum[31:0];
		end
	end

	always_comb begin
		rd_addr = idx_q[IW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_q;
		case (state_q)
			S_INSRD: rd_addr = IW'(idx_q - CW'(1));
			S_INSWR: wr_en = 1'b1;
			S_INSFIN: begin
				wr_en = 1'b1;
				wr_data = {key_q, qty_q, name_q & skrt_pkg::name_mask()};
			end
			S_ERRD: rd_addr = IW'(idx_q + CW'(1));
			S_ERWR: wr_en = 1'b1;
			S_UPD: begin
				wr_en = 1'b1;
				wr_data = {rd_key, sat, rd_q[199:0]};
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
			hit_q <= 1'b0;
			op_q <= skrt_pkg::OP_INSERT;
			key_q <= '0;
			qty_q <= '0;
			name_q <= '0;
			status <= skrt_pkg::ST_OK;
			out_key <= '0;
			out_quantity <= '0;
			out_name_a <= '0;
			out_name_b <= '0;
			out_name_c <= '0;
			out_name_d <= '0;
			last_result <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= operation;
						key_q <= part_key;
						qty_q <= quantity_value;
						name_q <= {name_word_d, name_word_c, name_word_b, name_word_a};
						idx_q <= '0;
						hit_q <= 1'b0;
						if (operation == skrt_pkg::OP_LIST) begin
							state_q <= S_LRD;
						end else if (operation <= skrt_pkg::OP_ERASE) begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (idx_q >= count_q) begin
						pos_q <= idx_q;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (rd_key < key_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end else begin
						pos_q <= idx_q;
						hit_q <= (rd_key == key_q);
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status <= skrt_pkg::ST_OK;
					out_key <= key_q;
					out_quantity <= '0;
					{out_name_d, out_name_c, out_name_b, out_name_a} <= '0;
					last_result <= 1'b1;
					state_q <= S_OUT;
					case (op_q)
						skrt_pkg::OP_INSERT: begin
							if (count_q == CW'(skrt_pkg::TABLE_DEPTH)) begin
								status <= skrt_pkg::ST_FULL;
							end else if (hit_q) begin
								status <= skrt_pkg::ST_DUPLICATE;
							end else begin
								idx_q <= count_q;
								state_q <= (count_q == pos_q) ? S_INSFIN : S_INSRD;
							end
						end
						skrt_pkg::OP_SEARCH, skrt_pkg::OP_ERASE: begin
							if (!hit_q) begin
								status <= skrt_pkg::ST_NOT_FOUND;
							end else begin
								out_key <= rd_key;
								out_quantity <= rd_qty;
								{out_name_d, out_name_c, out_name_b, out_name_a} <=
									rd_q[199:0];
								if (op_q == skrt_pkg::OP_ERASE) begin
									state_q <= (pos_q + CW'(1) == count_q) ?
										S_ERFIN : S_ERRD;
								end
							end
						end
						skrt_pkg::OP_UPDATE: begin
							if (!hit_q) begin
								status <= skrt_pkg::ST_NOT_FOUND;
							end else begin
								out_key <= rd_key;
								out_quantity <= sat;
								{out_name_d, out_name_c, out_name_b, out_name_a} <=
									rd_q[199:0];
								state_q <= S_UPD;
							end
						end
						default: ;
					endcase
				end
				S_UPD: state_q <= S_OUT;
				S_INSRD: state_q <= S_INSWR;
				S_INSWR: begin
					idx_q <= idx_q - CW'(1);
					state_q <= (idx_q - CW'(1) == pos_q) ? S_INSFIN : S_INSRD;
				end
				S_INSFIN: begin
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_ERRD: state_q <= S_ERWR;
				S_ERWR: begin
					idx_q <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(2) == count_q) ? S_ERFIN : S_ERRD;
				end
				S_ERFIN: begin
					count_q <= count_q - CW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LRD: begin
					if (count_q == '0) begin
						status <= skrt_pkg::ST_EMPTY;
						out_key <= '0;
						out_quantity <= '0;
						{out_name_d, out_name_c, out_name_b, out_name_a} <= '0;
						last_result <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LOUT;
					end
				end
				S_LOUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						status <= skrt_pkg::ST_OK;
						out_key <= rd_key;
						out_quantity <= rd_qty;
						{out_name_d, out_name_c, out_name_b, out_name_a} <= rd_q[199:0];
						last_result <= (idx_q + CW'(1) == count_q);
						idx_q <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == count_q) ? S_IDLE : S_LRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
